### rtl/core/receive_tsn_window_tracker_top_defines.svh
// Assertion macros for the receive TSN window tracker.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef RECEIVE_TSN_WINDOW_TRACKER_TOP_DEFINES_SVH
`define RECEIVE_TSN_WINDOW_TRACKER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RTWT_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("rtwt: %s", "lbl");
`define RTWT_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("rtwt: %s", "lbl");
`else
`define RTWT_ASSERT_IMP(lbl, a, c)
`define RTWT_ASSERT_NXT(lbl, a, c)
`endif
`endif

### rtl/core/rtwt_pkg.sv
// Shared constants, types and helpers of the receive TSN window tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rtwt_pkg;
  // window depth, power of two: slot index is the low TSN bits
  localparam int unsigned WINDOW_SLOTS = 64;
  localparam int unsigned IDX_W = $clog2(WINDOW_SLOTS);
  localparam int unsigned CNT_W = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned OFF_W = $clog2(WINDOW_SLOTS + 2);
  localparam int unsigned TSN_W = 32;
  localparam int unsigned CFG_W = 6;
  localparam int unsigned BLK_W = 7;
  localparam int unsigned MAX_ITEMS = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_REPORT = 2'd1;
  localparam logic [1:0] FUNC_RESET  = 2'd2;

  typedef struct packed {
    logic [TSN_W-1:0] tag;
    logic             begin_f;
    logic             end_f;
    logic             delivered;
  } rtwt_entry_t;

  localparam int unsigned ENTRY_W = $bits(rtwt_entry_t);

  typedef struct packed {
    logic             accepted;
    logic             packet_loss;
    logic             message_ready;
    logic [TSN_W-1:0] first_tsn;
    logic [TSN_W-1:0] last_tsn;
    logic [TSN_W-1:0] cumulative_tsn;
    logic             block_valid;
    logic [BLK_W-1:0] block_start;
    logic [BLK_W-1:0] block_end;
    logic             last;
  } rtwt_item_t;

  function automatic logic [IDX_W-1:0] idx_of(logic [TSN_W-1:0] t);
    return t[IDX_W-1:0];
  endfunction
endpackage
`default_nettype wire

### rtl/core/rtwt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rtwt_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/rtwt_engine.sv
// Sequencer of the TSN window: push, gap ack report and window reset.
// Depends on rtwt_pkg, rtwt_ram and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "receive_tsn_window_tracker_top_defines.svh"
module rtwt_engine (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               func_i,
  input  wire logic [rtwt_pkg::TSN_W-1:0] tsn_i,
  input  wire logic                     begin_flag_i,
  input  wire logic                     end_flag_i,
  input  wire logic [rtwt_pkg::CFG_W-1:0] lim_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output rtwt_pkg::rtwt_item_t          out_item_o
);
  localparam int unsigned W = rtwt_pkg::WINDOW_SLOTS;
  localparam int unsigned TW = rtwt_pkg::TSN_W;
  localparam int unsigned IW = rtwt_pkg::IDX_W;
  localparam int unsigned CW = rtwt_pkg::CNT_W;
  localparam int unsigned OW = rtwt_pkg::OFF_W;
  localparam int unsigned FW = rtwt_pkg::CFG_W;
  localparam int unsigned BW = rtwt_pkg::BLK_W;
  localparam int unsigned ENTRY_BITS = rtwt_pkg::ENTRY_W;

  typedef enum logic [3:0] {
    S_IDLE, S_ADV_RD, S_ADV_EV, S_LOSS, S_BK_RD, S_BK_EV, S_FW_RD, S_FW_EV,
    S_MK_RD, S_MK_WR, S_FR_RD, S_FR_EV, S_R_RD, S_R_EV, S_R_END, S_EMIT
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic [TW-1:0] cum_q, cum_d, t_q, t_d, x_q, x_d;
  logic [TW-1:0] first_q, first_d, last_q, last_d, n_q, n_d;
  logic [CW-1:0] k_q, k_d;
  logic [IW-1:0] fr_q, fr_d;
  logic [OW-1:0] off_q, off_d, bs_q, bs_d, be_q, be_d, pbs_q, pbs_d, pbe_q, pbe_d;
  logic [FW-1:0] nb_q, nb_d;
  logic          open_q, open_d, pend_q, pend_d, loss_q, loss_d, rdy_q, rdy_d;
  logic [W-1:0]  valid_q, valid_d;
  rtwt_pkg::rtwt_item_t stg_q, stg_d, out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  rtwt_pkg::rtwt_entry_t ram_wdata, ram_rdata;
  logic [ENTRY_BITS-1:0] ram_rbits;

  rtwt_ram #(
    .DATA_W(ENTRY_BITS),
    .DEPTH (W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rbits)
  );
  assign ram_rdata = rtwt_pkg::rtwt_entry_t'(ram_rbits);

  function automatic rtwt_pkg::rtwt_item_t plain_item(logic [TW-1:0] cum);
    rtwt_pkg::rtwt_item_t it;
    it = '0;
    it.cumulative_tsn = cum;
    it.last = 1'b1;
    return it;
  endfunction

  function automatic rtwt_pkg::rtwt_item_t blk_item(logic [TW-1:0] cum, logic [OW-1:0] bs,
                                                    logic [OW-1:0] be, logic lst);
    rtwt_pkg::rtwt_item_t it;
    logic [TW-1:0] bs_x;
    logic [TW-1:0] be_x;
    it = '0;
    bs_x = TW'(bs);
    be_x = TW'(be);
    it.cumulative_tsn = cum;
    it.block_valid = 1'b1;
    it.block_start = bs_x[BW-1:0];
    it.block_end = be_x[BW-1:0];
    it.last = lst;
    return it;
  endfunction

  logic [TW-1:0] d_push, adv_t, rep_t, fr_age;
  logic [FW-1:0] lim;
  logic          k_full, live, rep_hit;

  always_comb begin
    d_push  = tsn_i - cum_q;
    adv_t   = cum_q + TW'(1);
    rep_t   = cum_q + TW'(off_q);
    fr_age  = cum_q - ram_rdata.tag;
    k_full  = (k_q == CW'(W));
    live    = valid_q[rtwt_pkg::idx_of(x_q)] && (ram_rdata.tag == x_q) && !ram_rdata.delivered;
    rep_hit = valid_q[rtwt_pkg::idx_of(rep_t)] && (ram_rdata.tag == rep_t);
    lim     = (lim_i > FW'(rtwt_pkg::MAX_ITEMS)) ? FW'(rtwt_pkg::MAX_ITEMS) : lim_i;
  end

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    cum_d = cum_q; t_d = t_q; x_d = x_q; first_d = first_q; last_d = last_q; n_d = n_q;
    k_d = k_q; fr_d = fr_q; off_d = off_q; bs_d = bs_q; be_d = be_q;
    pbs_d = pbs_q; pbe_d = pbe_q; nb_d = nb_q; open_d = open_q; pend_d = pend_q;
    loss_d = loss_q; rdy_d = rdy_q; valid_d = valid_q; stg_d = stg_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we = 1'b0;
    ram_waddr = rtwt_pkg::idx_of(tsn_i);
    ram_wdata.tag = tsn_i;
    ram_wdata.begin_f = begin_flag_i;
    ram_wdata.end_f = end_flag_i;
    ram_wdata.delivered = 1'b0;
    ram_raddr = rtwt_pkg::idx_of(x_q);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ret_d = S_IDLE;
          stg_d = plain_item(cum_q);
          state_d = S_EMIT;
          case (func_i)
            rtwt_pkg::FUNC_PUSH: begin
              if (!(d_push == '0 || d_push > TW'(W) || valid_q[rtwt_pkg::idx_of(tsn_i)])) begin
                ram_we = 1'b1;
                valid_d[rtwt_pkg::idx_of(tsn_i)] = 1'b1;
                t_d = tsn_i;
                k_d = '0;
                state_d = S_ADV_RD;
              end
            end
            rtwt_pkg::FUNC_REPORT: begin
              off_d = OW'(1);
              nb_d = '0;
              open_d = 1'b0;
              pend_d = 1'b0;
              state_d = S_R_RD;
            end
            rtwt_pkg::FUNC_RESET: begin
              valid_d = '0;
              cum_d = '1;
              stg_d = plain_item('1);
            end
            default: ;
          endcase
        end
      end
      // cumulative point walks over the stored contiguous run
      S_ADV_RD: begin
        ram_raddr = rtwt_pkg::idx_of(adv_t);
        if (k_full || !valid_q[rtwt_pkg::idx_of(adv_t)]) begin
          state_d = S_LOSS;
        end else begin
          state_d = S_ADV_EV;
        end
      end
      S_ADV_EV: begin
        if (ram_rdata.tag == adv_t) begin
          cum_d = adv_t;
          k_d = k_q + CW'(1);
          state_d = S_ADV_RD;
        end else begin
          state_d = S_LOSS;
        end
      end
      S_LOSS: begin
        x_d = t_q - cum_q;
        loss_d = (x_d != '0) && !x_d[TW-1];
        x_d = t_q;
        k_d = '0;
        rdy_d = 1'b0;
        first_d = '0;
        last_d = '0;
        state_d = S_BK_RD;
      end
      S_BK_RD: begin
        if (k_full) begin
          fr_d = '0;
          state_d = S_FR_RD;
        end else begin
          state_d = S_BK_EV;
        end
      end
      S_BK_EV: begin
        if (!live) begin
          fr_d = '0;
          state_d = S_FR_RD;
        end else if (ram_rdata.begin_f) begin
          first_d = x_q;
          x_d = t_q;
          k_d = '0;
          state_d = S_FW_RD;
        end else begin
          x_d = x_q - TW'(1);
          k_d = k_q + CW'(1);
          state_d = S_BK_RD;
        end
      end
      S_FW_RD: begin
        if (k_full) begin
          first_d = '0;
          fr_d = '0;
          state_d = S_FR_RD;
        end else begin
          state_d = S_FW_EV;
        end
      end
      S_FW_EV: begin
        if (!live) begin
          first_d = '0;
          fr_d = '0;
          state_d = S_FR_RD;
        end else if (ram_rdata.end_f) begin
          last_d = x_q;
          n_d = x_q - first_q + TW'(1);
          x_d = first_q;
          k_d = '0;
          rdy_d = 1'b1;
          state_d = S_MK_RD;
        end else begin
          x_d = x_q + TW'(1);
          k_d = k_q + CW'(1);
          state_d = S_FW_RD;
        end
      end
      S_MK_RD: begin
        if (k_full || TW'(k_q) >= n_q) begin
          fr_d = '0;
          state_d = S_FR_RD;
        end else begin
          state_d = S_MK_WR;
        end
      end
      S_MK_WR: begin
        ram_we = 1'b1;
        ram_waddr = rtwt_pkg::idx_of(x_q);
        ram_wdata = ram_rdata;
        ram_wdata.delivered = 1'b1;
        x_d = x_q + TW'(1);
        k_d = k_q + CW'(1);
        state_d = S_MK_RD;
      end
      // free delivered slots at or below the cumulative point
      S_FR_RD: begin
        ram_raddr = fr_q;
        if (valid_q[fr_q]) begin
          state_d = S_FR_EV;
        end else if (fr_q == IW'(W - 1)) begin
          stg_d = plain_item(cum_q);
          stg_d.accepted = 1'b1;
          stg_d.packet_loss = loss_q;
          stg_d.message_ready = rdy_q;
          stg_d.first_tsn = first_q;
          stg_d.last_tsn = last_q;
          ret_d = S_IDLE;
          state_d = S_EMIT;
        end else begin
          fr_d = fr_q + IW'(1);
        end
      end
      S_FR_EV: begin
        if (ram_rdata.delivered && !fr_age[TW-1]) begin
          valid_d[fr_q] = 1'b0;
        end
        if (fr_q == IW'(W - 1)) begin
          stg_d = plain_item(cum_q);
          stg_d.accepted = 1'b1;
          stg_d.packet_loss = loss_q;
          stg_d.message_ready = rdy_q;
          stg_d.first_tsn = first_q;
          stg_d.last_tsn = last_q;
          ret_d = S_IDLE;
          state_d = S_EMIT;
        end else begin
          fr_d = fr_q + IW'(1);
          state_d = S_FR_RD;
        end
      end
      // gap ack walk; one block held back so the final one can carry last
      S_R_RD: begin
        ram_raddr = rtwt_pkg::idx_of(rep_t);
        if (off_q > OW'(W)) begin
          state_d = S_R_END;
        end else begin
          state_d = S_R_EV;
        end
      end
      S_R_EV: begin
        off_d = off_q + OW'(1);
        state_d = S_R_RD;
        if (rep_hit) begin
          if (open_q) begin
            be_d = off_q;
          end else if (nb_q >= lim) begin
            off_d = off_q;
            state_d = S_R_END;
          end else begin
            open_d = 1'b1;
            bs_d = off_q;
            be_d = off_q;
          end
        end else if (open_q) begin
          nb_d = nb_q + FW'(1);
          open_d = 1'b0;
          pend_d = 1'b1;
          pbs_d = bs_q;
          pbe_d = be_q;
          if (pend_q) begin
            stg_d = blk_item(cum_q, pbs_q, pbe_q, 1'b0);
            ret_d = S_R_RD;
            state_d = S_EMIT;
          end
        end
      end
      S_R_END: begin
        if (open_q) begin
          nb_d = nb_q + FW'(1);
          open_d = 1'b0;
          pend_d = 1'b1;
          pbs_d = bs_q;
          pbe_d = be_q;
          if (pend_q) begin
            stg_d = blk_item(cum_q, pbs_q, pbe_q, 1'b0);
            ret_d = S_R_END;
            state_d = S_EMIT;
          end
        end else begin
          stg_d = pend_q ? blk_item(cum_q, pbs_q, pbe_q, 1'b1) : plain_item(cum_q);
          ret_d = S_IDLE;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d = stg_q;
          out_valid_d = 1'b1;
          state_d = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      cum_q <= '1;
      valid_q <= '0;
      out_valid_q <= 1'b0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      cum_q <= cum_d;
      valid_q <= valid_d;
      out_valid_q <= out_valid_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d; x_q <= x_d; first_q <= first_d; last_q <= last_d; n_q <= n_d;
    fr_q <= fr_d; off_q <= off_d; bs_q <= bs_d; be_q <= be_d;
    pbs_q <= pbs_d; pbe_q <= pbe_d; nb_q <= nb_d; open_q <= open_d;
    pend_q <= pend_d; loss_q <= loss_d; rdy_q <= rdy_d; stg_q <= stg_d; out_q <= out_d;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  `RTWT_ASSERT_NXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != S_IDLE)
  `RTWT_ASSERT_IMP(a_ram_write_src, ram_we, state_q == S_IDLE || state_q == S_MK_WR)
  `RTWT_ASSERT_NXT(a_emit_loads, state_q == S_EMIT && (!out_valid_q || !out_stall_i),
                   out_valid_q && out_q == $past(stg_q))
  `RTWT_ASSERT_IMP(a_walk_bound, 1'b1, k_q <= CW'(W))
endmodule
`default_nettype wire

### rtl/core/receive_tsn_window_tracker_top.sv
// Top level of the receive TSN window tracker: config register and port breakout.
// Depends on rtwt_pkg and rtwt_engine.
`timescale 1ns / 1ps
`default_nettype none
// Receive TSN window over 64 slots kept in one RAM with a registered read port; most
// slot visits are a read state followed by an evaluate state. A rejected push only loads
// the output. An accepted push advances the cumulative TSN, walks back and forward through
// the message run, marks a complete message's slots delivered, then runs a freeing sweep
// over all 64 slots and loads the output. A report walks the window offsets and emits one
// item per gap block, or a plain item if there is none. A reset clears the window and, like
// an unused code, loads a plain result. One item is in work at a time; in_stall_o is high
// until its last result is loaded into the output register.
module receive_tsn_window_tracker_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 func_i,
  input  wire logic [rtwt_pkg::TSN_W-1:0] tsn_i,
  input  wire logic                       begin_flag_i,
  input  wire logic                       end_flag_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            accepted_o,
  output logic                            packet_loss_o,
  output logic                            message_ready_o,
  output logic [rtwt_pkg::TSN_W-1:0]      first_tsn_o,
  output logic [rtwt_pkg::TSN_W-1:0]      last_tsn_o,
  output logic [rtwt_pkg::TSN_W-1:0]      cumulative_tsn_o,
  output logic                            block_valid_o,
  output logic [rtwt_pkg::BLK_W-1:0]      block_start_o,
  output logic [rtwt_pkg::BLK_W-1:0]      block_end_o,
  output logic                            last_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [rtwt_pkg::CFG_W-1:0] cfg_data_i
);
  logic [rtwt_pkg::CFG_W-1:0] max_blocks_q, max_blocks_d;
  rtwt_pkg::rtwt_item_t item;

  assign cfg_ready_o = 1'b1;
  assign max_blocks_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : max_blocks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_blocks_q <= rtwt_pkg::CFG_RESET;
    end else begin
      max_blocks_q <= max_blocks_d;
    end
  end

  rtwt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .tsn_i       (tsn_i),
    .begin_flag_i(begin_flag_i),
    .end_flag_i  (end_flag_i),
    .lim_i       (max_blocks_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (item)
  );

  assign accepted_o       = item.accepted;
  assign packet_loss_o    = item.packet_loss;
  assign message_ready_o  = item.message_ready;
  assign first_tsn_o      = item.first_tsn;
  assign last_tsn_o       = item.last_tsn;
  assign cumulative_tsn_o = item.cumulative_tsn;
  assign block_valid_o    = item.block_valid;
  assign block_start_o    = item.block_start;
  assign block_end_o      = item.block_end;
  assign last_o           = item.last;
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking bench for the receive TSN window tracker: push, report and reset traffic.
// Depends on rtwt_pkg and receive_tsn_window_tracker_top; predicts every result item.
`timescale 1ns / 1ps
module tb_top;
  // the one func code the block ignores
  localparam logic [1:0] FUNC_IDLE = 2'd3;

  typedef struct packed {
    logic [1:0]                 func;
    logic [rtwt_pkg::TSN_W-1:0] tsn;
    logic                       bflag;
    logic                       eflag;
  } frag_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] func_i = '0;
  logic [rtwt_pkg::TSN_W-1:0] tsn_i = '0;
  logic begin_flag_i = 1'b0, end_flag_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic accepted_o, packet_loss_o, message_ready_o;
  logic [rtwt_pkg::TSN_W-1:0] first_tsn_o, last_tsn_o, cumulative_tsn_o;
  logic block_valid_o;
  logic [rtwt_pkg::BLK_W-1:0] block_start_o, block_end_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rtwt_pkg::CFG_W-1:0] cfg_data_i = '0;

  receive_tsn_window_tracker_top dut (.*);

  initial forever #4 clk_i = ~clk_i;

  // predictor state
  logic [31:0] p_cum;
  logic [31:0] p_tag [rtwt_pkg::WINDOW_SLOTS];
  logic        p_vld [rtwt_pkg::WINDOW_SLOTS];
  logic        p_beg [rtwt_pkg::WINDOW_SLOTS];
  logic        p_end [rtwt_pkg::WINDOW_SLOTS];
  logic        p_dlv [rtwt_pkg::WINDOW_SLOTS];
  logic [5:0]  p_maxblk;
  logic [5:0]  cfgs [6];

  frag_t                frag_q[$];
  rtwt_pkg::rtwt_item_t result_q[$];
  int errors = 0, n_pushes = 0, n_reports = 0, n_msgs = 0, n_blocks = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit hold_send = 0;

  function automatic bit holds(logic [31:0] t);
    return p_vld[t[5:0]] && p_tag[t[5:0]] == t;
  endfunction

  function automatic bit live(logic [31:0] t);
    return holds(t) && !p_dlv[t[5:0]];
  endfunction

  function automatic rtwt_pkg::rtwt_item_t blank();
    rtwt_pkg::rtwt_item_t r;
    r = '0;
    r.cumulative_tsn = p_cum;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_push(frag_t f);
    rtwt_pkg::rtwt_item_t r;
    logic [31:0] d, x, first, lastt;
    logic [5:0] i;
    bit fb, fe;
    d = f.tsn - p_cum;
    i = f.tsn[5:0];
    fb = 0; fe = 0; first = 0; lastt = 0;
    if (d == 0 || d > rtwt_pkg::WINDOW_SLOTS || p_vld[i]) begin
      result_q.push_back(blank());
      return;
    end
    p_vld[i] = 1; p_tag[i] = f.tsn; p_beg[i] = f.bflag; p_end[i] = f.eflag; p_dlv[i] = 0;
    for (int k = 0; k < rtwt_pkg::WINDOW_SLOTS && holds(p_cum + 1); k++) p_cum++;
    r = blank();
    r.accepted = 1'b1;
    d = f.tsn - p_cum;
    r.packet_loss = (d != 0) && !d[31];
    for (int k = 0; k < rtwt_pkg::WINDOW_SLOTS; k++) begin
      x = f.tsn - k;
      if (!live(x)) break;
      if (p_beg[x[5:0]]) begin first = x; fb = 1; break; end
    end
    if (fb)
      for (int k = 0; k < rtwt_pkg::WINDOW_SLOTS; k++) begin
        x = f.tsn + k;
        if (!live(x)) break;
        if (p_end[x[5:0]]) begin lastt = x; fe = 1; break; end
      end
    if (fb && fe) begin
      d = lastt - first + 1;
      for (int k = 0; k < d && k < rtwt_pkg::WINDOW_SLOTS; k++) begin
        x = first + k;
        p_dlv[x[5:0]] = 1;
      end
      r.message_ready = 1; r.first_tsn = first; r.last_tsn = lastt;
      n_msgs++;
    end
    for (int k = 0; k < rtwt_pkg::WINDOW_SLOTS; k++) begin
      x = p_cum - p_tag[k];
      if (p_vld[k] && p_dlv[k] && !x[31]) p_vld[k] = 0;
    end
    result_q.push_back(r);
  endtask

  task automatic predict_report();
    rtwt_pkg::rtwt_item_t r;
    int lim, n, bs, be;
    bit open;
    lim = p_maxblk > rtwt_pkg::MAX_ITEMS ? rtwt_pkg::MAX_ITEMS : p_maxblk;
    n = 0; open = 0; bs = 0; be = 0;
    r = '0;
    r.cumulative_tsn = p_cum;
    r.block_valid = 1;
    for (int off = 1; off <= rtwt_pkg::WINDOW_SLOTS; off++) begin
      if (holds(p_cum + off)) begin
        if (open) be = off;
        else begin
          if (n >= lim) break;
          open = 1; bs = off; be = off;
        end
      end else if (open) begin
        r.block_start = rtwt_pkg::BLK_W'(bs); r.block_end = rtwt_pkg::BLK_W'(be);
        result_q.push_back(r); n++; open = 0;
      end
    end
    if (open) begin
      r.block_start = rtwt_pkg::BLK_W'(bs); r.block_end = rtwt_pkg::BLK_W'(be);
      result_q.push_back(r); n++;
    end
    if (n == 0) result_q.push_back(blank());
    else result_q[$].last = 1'b1;
    n_blocks += n;
  endtask

  task automatic predict(frag_t f);
    case (f.func)
      rtwt_pkg::FUNC_PUSH: begin predict_push(f); n_pushes++; end
      rtwt_pkg::FUNC_REPORT: begin predict_report(); n_reports++; end
      default: begin
        if (f.func == rtwt_pkg::FUNC_RESET) begin
          p_cum = '1;
          foreach (p_vld[k]) p_vld[k] = 0;
        end
        result_q.push_back(blank());
      end
    endcase
  endtask

  // driver
  int gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict(frag_q.pop_front());
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap > 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (frag_q.size() > 0 && !hold_send) begin
          in_valid_i <= 1'b1;
          func_i <= frag_q[0].func;
          tsn_i <= frag_q[0].tsn;
          begin_flag_i <= frag_q[0].bflag;
          end_flag_i <= frag_q[0].eflag;
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rtwt_pkg::rtwt_item_t got, exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{accepted_o, packet_loss_o, message_ready_o, first_tsn_o, last_tsn_o,
                cumulative_tsn_o, block_valid_o, block_start_o, block_end_o, last_o};
        if (result_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %p", $realtime, got);
          errors++;
        end else begin
          exp_r = result_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t mismatch: expected %p, actual %p", $realtime, exp_r, got);
            errors++;
          end
        end
      end
      // mostly short stalls, now and then a long one
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 29) == 0) begin
        stall_left = $urandom_range(5, 40);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 4) == 0);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("watchdog: no transfer for 20000 cycles");
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic frag_t mk(logic [1:0] fn, logic [31:0] t, bit b, bit e);
    frag_t f;
    f.func = fn; f.tsn = t; f.bflag = b; f.eflag = e;
    return f;
  endfunction

  task automatic wait_drain();
    while (frag_q.size() > 0 || result_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [5:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    p_maxblk = v;
    cfg_valid_i <= 1'b0;
  endtask

  // one random phase; base is the window origin the stream is aimed at
  task automatic random_phase(int count);
    logic [31:0] base;
    int sel;
    frag_q.push_back(mk(rtwt_pkg::FUNC_RESET, 0, 0, 0));
    base = '1;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70)
        frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, base + $urandom_range(1, 20),
                            $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0));
      else if (sel < 80) begin
        frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, $urandom(), $urandom, $urandom));
        frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, base + $urandom_range(1, 70),
                            $urandom, $urandom));
      end else if (sel < 92)
        frag_q.push_back(mk(rtwt_pkg::FUNC_REPORT, $urandom(), $urandom, $urandom));
      else if (sel < 95) frag_q.push_back(mk(FUNC_IDLE, $urandom(), $urandom, $urandom));
      else begin
        frag_q.push_back(mk(rtwt_pkg::FUNC_RESET, $urandom(), $urandom, $urandom));
      end
      // move the aim forward so the window slides
      if ($urandom_range(0, 5) == 0) base = base + $urandom_range(1, 8);
      if (sel >= 95) base = '1;
    end
  endtask

  initial begin
    cfgs = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd3, 6'd32};
    p_maxblk = rtwt_pkg::CFG_RESET;
    p_cum = '1;
    foreach (p_vld[k]) begin
      p_vld[k] = 0; p_tag[k] = 0; p_beg[k] = 0; p_end[k] = 0; p_dlv[k] = 0;
    end
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cfg(6'd32);
    // directed: single message, holes, duplicates, out of window, wrap, reports
    frag_q.push_back(mk(rtwt_pkg::FUNC_REPORT, 0, 0, 0));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 1, 1));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'd0, 1, 1));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'd0, 1, 1));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'd65, 0, 0));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'd64, 0, 1));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'd3, 0, 0));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'd5, 1, 0));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'd7, 0, 1));
    frag_q.push_back(mk(rtwt_pkg::FUNC_REPORT, 0, 0, 0));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'd6, 0, 0));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'd1, 1, 0));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'd2, 0, 1));
    frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'd4, 0, 0));
    frag_q.push_back(mk(rtwt_pkg::FUNC_REPORT, 0, 0, 0));
    frag_q.push_back(mk(FUNC_IDLE, 32'hFFFF_FFFF, 1, 1));
    frag_q.push_back(mk(rtwt_pkg::FUNC_RESET, 32'hFFFF_FFFF, 1, 1));
    for (int k = 0; k < 8; k++)
      frag_q.push_back(mk(rtwt_pkg::FUNC_PUSH, 32'(2 * k + 1), k[0], 1));
    frag_q.push_back(mk(rtwt_pkg::FUNC_REPORT, 0, 0, 0));
    wait_drain();
    foreach (cfgs[c]) begin
      write_cfg(cfgs[c]);
      random_phase(45);
      if (c == 2) begin
        // sender holds off until the tracker has drained
        while (frag_q.size() > 40) @(posedge clk_i);
        hold_send = 1;
        while (result_q.size() > 0 || in_valid_i) @(posedge clk_i);
        hold_send = 0;
      end
      wait_drain();
    end
    $display("covered %0d pushes, %0d reports, %0d messages delivered, %0d gap blocks",
             n_pushes, n_reports, n_msgs, n_blocks);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
